>>> rtl/sdcrc_pkg.sv
// Package with constants, types and CRC helper functions for the SD 4-bit data CRC engine.
package sdcrc_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int CRC_BYTES = 8;
  localparam int POS_W = $clog2(BLOCK_BYTES + CRC_BYTES + 1);
  localparam int BURST_W = $clog2(CRC_BYTES + 1);
  localparam int LINES = 4;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [ADDR_W-3:0] REG_CHECK_MODE = '0;

  typedef logic [LINES-1:0][15:0] crc_arr_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_crc;
    logic       block_end;
    logic       crc_match;
  } res_t;

  function automatic logic [15:0] crc_bit(input logic [15:0] crc, input logic din);
    logic [15:0] nxt;
    nxt = {crc[14:0], 1'b0};
    if (crc[15] ^ din) begin
      nxt = nxt ^ CRC_POLY;
    end
    return nxt;
  endfunction

  function automatic crc_arr_t crc_update_byte(input crc_arr_t crc, input logic [7:0] d);
    crc_arr_t res;
    for (int i = 0; i < LINES; i++) begin
      res[i] = crc_bit(crc_bit(crc[i], d[4+i]), d[i]);
    end
    return res;
  endfunction

  function automatic logic [7:0] crc_top_byte(input crc_arr_t crc);
    logic [7:0] b;
    for (int i = 0; i < LINES; i++) begin
      b[4+i] = crc[i][15];
      b[i] = crc[i][14];
    end
    return b;
  endfunction

  function automatic crc_arr_t crc_shift2(input crc_arr_t crc);
    crc_arr_t res;
    for (int i = 0; i < LINES; i++) begin
      res[i] = {crc[i][13:0], 2'b00};
    end
    return res;
  endfunction

endpackage

>>> rtl/sd_dat4_crc16_engine_unit.sv
// Per-line CRC-16 engine for a 4-bit SD data bus with generate and check modes.
//
// Input channel: in_valid/in_stall carry one byte per transfer in in_data_byte.
// Output channel: out_valid/out_stall carry one result per transfer.
// Configuration: APB-style port; register 0 holds check_mode (0 generate, 1 check).
//
// Each accepted data byte is echoed through the output register, and a new byte
// can be taken in every cycle while in_stall is low. In generate mode the last byte of a
// block is followed by eight CRC bytes, one per cycle while the skid register is
// empty, and the input channel is stalled while they are sent. In check mode
// the eight received CRC bytes produce no result except the last, which gives one
// result with block_end set and crc_match reporting the comparison.
//
// The output register is backed by a one-entry skid register, so a byte is still
// taken while a result waits; in_stall rises once the skid register is full.
// Reset clears the CRCs, the byte counter, the mismatch flag, check_mode and both
// output valid flags. No clearing pass is needed after reset.
module sd_dat4_crc16_engine_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_data_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_out_byte,
  output logic                             out_is_crc,
  output logic                             out_block_end,
  output logic                             out_crc_match,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sdcrc_pkg::ADDR_W-1:0]     paddr,
  input  logic [sdcrc_pkg::DATA_W-1:0]     pwdata,
  output logic [sdcrc_pkg::DATA_W-1:0]     prdata,
  output logic                             pready
);

  localparam logic [sdcrc_pkg::POS_W-1:0] POS_BLOCK =
    sdcrc_pkg::POS_W'(sdcrc_pkg::BLOCK_BYTES);
  localparam logic [sdcrc_pkg::POS_W-1:0] POS_LAST =
    sdcrc_pkg::POS_W'(sdcrc_pkg::BLOCK_BYTES + sdcrc_pkg::CRC_BYTES - 1);
  localparam logic [sdcrc_pkg::BURST_W-1:0] BURST_LEN =
    sdcrc_pkg::BURST_W'(sdcrc_pkg::CRC_BYTES);

  logic                            check_mode_r;
  sdcrc_pkg::crc_arr_t             crc_r, crc_nxt, crc_base;
  logic [sdcrc_pkg::POS_W-1:0]     pos_r, pos_nxt, pos_base;
  logic                            mism_r, mism_nxt, mism_base;
  logic [sdcrc_pkg::BURST_W-1:0]   burst_r, burst_nxt;
  logic                            out_valid_r, skid_valid_r;
  sdcrc_pkg::res_t                 out_r, skid_r, push_res;
  logic                            push;
  logic                            in_fire, out_fire, burst_active, crc_phase, diff;
  logic                            cfg_wr;

  assign burst_active = (burst_r != '0);
  assign in_stall = skid_valid_r || burst_active;
  assign in_fire = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;
  assign crc_phase = (pos_r >= POS_BLOCK);
  assign diff = (sdcrc_pkg::crc_top_byte(crc_r) != in_data_byte);

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[sdcrc_pkg::ADDR_W-1:2] == sdcrc_pkg::REG_CHECK_MODE) ?
                  {{(sdcrc_pkg::DATA_W-1){1'b0}}, check_mode_r} : '0;

  always_comb begin
    crc_nxt = crc_r;
    pos_nxt = pos_r;
    mism_nxt = mism_r;
    burst_nxt = burst_r;
    push = 1'b0;
    push_res = '0;
    crc_base = crc_phase ? '0 : crc_r;
    pos_base = crc_phase ? '0 : pos_r;
    mism_base = crc_phase ? 1'b0 : mism_r;
    if (in_fire) begin
      if (crc_phase && check_mode_r) begin
        crc_nxt = sdcrc_pkg::crc_shift2(crc_r);
        mism_nxt = mism_r | diff;
        pos_nxt = pos_r + 1'b1;
        if (pos_r == POS_LAST) begin
          push = 1'b1;
          push_res.block_end = 1'b1;
          push_res.crc_match = ~(mism_r | diff);
          crc_nxt = '0;
          pos_nxt = '0;
          mism_nxt = 1'b0;
        end
      end else begin
        crc_nxt = sdcrc_pkg::crc_update_byte(crc_base, in_data_byte);
        pos_nxt = pos_base + 1'b1;
        mism_nxt = mism_base;
        push = 1'b1;
        push_res.out_byte = in_data_byte;
        if ((pos_nxt >= POS_BLOCK) && !check_mode_r) begin
          pos_nxt = '0;
          mism_nxt = 1'b0;
          burst_nxt = BURST_LEN;
        end
      end
    end else if (burst_active && !skid_valid_r) begin
      push = 1'b1;
      push_res.out_byte = sdcrc_pkg::crc_top_byte(crc_r);
      push_res.is_crc = 1'b1;
      push_res.block_end = (burst_r == sdcrc_pkg::BURST_W'(1));
      crc_nxt = sdcrc_pkg::crc_shift2(crc_r);
      burst_nxt = burst_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_mode_r <= 1'b0;
      crc_r <= '0;
      pos_r <= '0;
      mism_r <= 1'b0;
      burst_r <= '0;
    end else begin
      if (cfg_wr && (paddr[sdcrc_pkg::ADDR_W-1:2] == sdcrc_pkg::REG_CHECK_MODE)) begin
        check_mode_r <= pwdata[0];
      end
      crc_r <= crc_nxt;
      pos_r <= pos_nxt;
      mism_r <= mism_nxt;
      burst_r <= burst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (push) begin
        out_r <= push_res;
      end
    end else if (push) begin
      skid_r <= push_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_out_byte = out_r.out_byte;
  assign out_is_crc = out_r.is_crc;
  assign out_block_end = out_r.block_end;
  assign out_crc_match = out_r.crc_match;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("Skid entry held while output register is empty.");

  a_crc_clear_after_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (burst_r == sdcrc_pkg::BURST_W'(1)) && !skid_valid_r |=> (crc_r == '0))
    else $error("Line CRCs not cleared after the last CRC byte.");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("Byte position beyond the CRC phase.");

  a_burst_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    burst_active |-> (pos_r == '0) && !mism_r)
    else $error("Block state not cleared during CRC output.");
`endif

endmodule
